// ===== sv/cbm_pkg.sv =====
package cbm_pkg;

  // Input request modes
  localparam logic [1:0] MODE_WR    = 2'd0;
  localparam logic [1:0] MODE_RD    = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;
  localparam logic [1:0] MODE_LATCH = 2'd3;

  // Result kinds
  localparam logic [2:0] KIND_FINAL  = 3'd0;
  localparam logic [2:0] KIND_PRG    = 3'd1;
  localparam logic [2:0] KIND_SRAM   = 3'd2;
  localparam logic [2:0] KIND_PROT   = 3'd3;
  localparam logic [2:0] KIND_CHR    = 3'd4;
  localparam logic [2:0] KIND_MIRROR = 3'd5;

  // Register addresses
  localparam logic [15:0] A_PRG_MODE = 16'h5100;
  localparam logic [15:0] A_CHR_MODE = 16'h5101;
  localparam logic [15:0] A_KEY_A    = 16'h5102;
  localparam logic [15:0] A_KEY_B    = 16'h5103;
  localparam logic [15:0] A_EXT_MODE = 16'h5104;
  localparam logic [15:0] A_MIRROR   = 16'h5105;
  localparam logic [15:0] A_SRAM     = 16'h5113;
  localparam logic [15:0] A_CHR_UP   = 16'h5130;
  localparam logic [15:0] A_IRQ_CMP  = 16'h5203;
  localparam logic [15:0] A_IRQ_ST   = 16'h5204;
  localparam logic [15:0] A_MUL_A    = 16'h5205;
  localparam logic [15:0] A_MUL_B    = 16'h5206;

  // Register address ranges
  localparam logic [15:0] A_PRG_PG_LO = 16'h5114;
  localparam logic [15:0] A_PRG_PG_HI = 16'h5117;
  localparam logic [15:0] A_CHR0_LO   = 16'h5120;
  localparam logic [15:0] A_CHR0_HI   = 16'h5127;
  localparam logic [15:0] A_CHR1_LO   = 16'h5128;
  localparam logic [15:0] A_CHR1_HI   = 16'h512b;
  localparam logic [15:0] A_EXT_LO    = 16'h5c00;
  localparam logic [15:0] A_EXT_HI    = 16'h5fff;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_EMIT, ST_WAIT
  } state_t;

  // One result item
  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  slot;
    logic [12:0] bank;
  } item_t;

endpackage

// ===== sv/cartridge_bank_mapper_irq.sv =====
// Cartridge bank controller with scanline interrupt.
// Input channel in_*: one bus event per request (cpu write, cpu read,
// scanline tick, fetch latch). Output channel out_*: up to eight slot
// remap requests followed by one final request with out_last=1, carrying
// read data; out_irq is the line level after the event on every request.
// Each event goes from ST_READ, where its plan is built from the registered
// extended RAM read, to ST_EMIT, which sends its result items; one event is
// worked at a time and in_stall stays high until its final item is taken.
// Results are produced one per cycle from the event's plan; a high
// out_stall holds the current result steady and the sequence waits.
// After reset the extended RAM is swept to zero, one entry per cycle,
// until its last entry is cleared, during which in_stall is high. All other
// mapper registers take their power-up values at once.
// Multiplier reads use one 8x8 multiply of the stored operands.
module cartridge_bank_mapper_irq #(
  parameter int EXT_RAM_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [15:0] in_addr,
  input  logic [7:0]  in_data,
  input  logic [8:0]  in_scanline,
  input  logic        in_rendering_enabled,
  input  logic        in_fetch_set,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [2:0]  out_slot,
  output logic [12:0] out_bank,
  output logic [7:0]  out_read_data,
  output logic        out_irq,
  output logic        out_last
);
  localparam int AW = $clog2(EXT_RAM_DEPTH);

  cbm_pkg::state_t state_r, state_nxt;

  // Registers of the mapper
  logic [1:0] prg_mode_r, chr_mode_r, key_a_r, key_b_r, ext_mode_r, upper_r;
  logic [7:0] chr_regs_r [16];
  logic [7:0] cmp_r, mcand_r, mplier_r;
  logic       irq_en_r, pend_r, vbl_r, irq_r;

  // Latched request
  logic [1:0]  mode_r;
  logic [15:0] addr_r;
  logic [7:0]  data_r;
  logic [8:0]  line_r;
  logic        rend_r, fset_r;

  // Extended RAM
  logic [7:0]    ram [EXT_RAM_DEPTH];
  logic [7:0]    ram_q;
  logic [AW-1:0] clr_r;

  // Plan of result items
  cbm_pkg::item_t plan_r [8];
  logic [3:0]     cnt_r, idx_r;
  logic [7:0]     rd_r;

  logic acc_in, out_take;
  assign acc_in   = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  logic in_ext;
  assign in_ext = (addr_r >= cbm_pkg::A_EXT_LO) && (addr_r <= cbm_pkg::A_EXT_HI);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cbm_pkg::ST_CLEAR: if (clr_r == AW'(EXT_RAM_DEPTH - 1)) state_nxt = cbm_pkg::ST_IDLE;
      cbm_pkg::ST_IDLE:  if (acc_in) state_nxt = cbm_pkg::ST_READ;
      cbm_pkg::ST_READ:  state_nxt = cbm_pkg::ST_EMIT;
      cbm_pkg::ST_EMIT:  if (out_take && idx_r == cnt_r) state_nxt = cbm_pkg::ST_IDLE;
      cbm_pkg::ST_WAIT:  state_nxt = cbm_pkg::ST_IDLE;
      default:           state_nxt = cbm_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall  = (state_r != cbm_pkg::ST_IDLE);
    out_valid = (state_r == cbm_pkg::ST_EMIT);
    out_last  = (idx_r == cnt_r);
    if (out_last) begin
      out_kind = cbm_pkg::KIND_FINAL;
      out_slot = 3'd0;
      out_bank = 13'd0;
      out_read_data = rd_r;
    end else begin
      out_kind = plan_r[idx_r[2:0]].kind;
      out_slot = plan_r[idx_r[2:0]].slot;
      out_bank = plan_r[idx_r[2:0]].bank;
      out_read_data = 8'd0;
    end
    out_irq = irq_r;
  end

  // Memory port: sweep, write, read
  always_ff @(posedge clk) begin
    if (state_r == cbm_pkg::ST_CLEAR) ram[clr_r] <= 8'd0;
    else if (acc_in && in_mode == cbm_pkg::MODE_WR && in_addr >= cbm_pkg::A_EXT_LO
             && in_addr <= cbm_pkg::A_EXT_HI)
      ram[in_addr[AW-1:0]] <= in_data;
    ram_q <= ram[in_addr[AW-1:0]];
  end

  // Plan build helpers
  function automatic logic [12:0] chr_bank(input logic [1:0] cm, input logic [1:0] up,
                                           input logic [7:0] r, input logic [2:0] s);
    logic [9:0] v;
    v = {up, r};
    case (cm)
      2'd0:    chr_bank = {v, s};
      2'd1:    chr_bank = {1'b0, v, s[1:0]};
      2'd2:    chr_bank = {2'b0, v, s[0]};
      default: chr_bank = {3'b0, v};
    endcase
  endfunction

  function automatic logic [3:0] chr_idx(input logic [1:0] cm, input logic [2:0] s);
    case (cm)
      2'd0:    chr_idx = 4'd7;
      2'd1:    chr_idx = s[2] ? 4'd7 : 4'd3;
      2'd2:    chr_idx = {1'b0, s[2:1], 1'b1};
      default: chr_idx = {1'b0, s};
    endcase
  endfunction

  cbm_pkg::item_t plan_nxt [8];
  logic [3:0]     cnt_nxt;
  logic [7:0]     rd_nxt;
  logic [15:0]    prod;
  logic           prot;
  logic [2:0]     pg;
  logic [1:0]     pm;
  logic [7:0]     regs_v [16];

  always_comb begin
    for (int i = 0; i < 8; i++) plan_nxt[i] = '0;
    cnt_nxt = 4'd0;
    rd_nxt  = 8'd0;
    prod    = mcand_r * mplier_r;
    pg      = addr_r[2:0];
    pm      = prg_mode_r;
    for (int i = 0; i < 16; i++) regs_v[i] = chr_regs_r[i];
    // keys and CHR set 0 as updated by this write
    prot = !(key_a_r == 2'd2 && key_b_r == 2'd1);
    if (mode_r == cbm_pkg::MODE_WR) begin
      if (addr_r == cbm_pkg::A_KEY_A)
        prot = !(data_r[1:0] == 2'd2 && key_b_r == 2'd1);
      if (addr_r == cbm_pkg::A_KEY_B)
        prot = !(key_a_r == 2'd2 && data_r[1:0] == 2'd1);
      if (addr_r >= cbm_pkg::A_CHR0_LO && addr_r <= cbm_pkg::A_CHR0_HI)
        regs_v[{1'b0, pg}] = data_r;
    end
    unique case (mode_r)
      cbm_pkg::MODE_WR: begin
        if (addr_r == cbm_pkg::A_KEY_A || addr_r == cbm_pkg::A_KEY_B) begin
          for (int i = 0; i < 4; i++)
            plan_nxt[i] = '{cbm_pkg::KIND_PROT, 3'(3 + i), {12'd0, prot}};
          cnt_nxt = 4'd4;
        end else if (addr_r == cbm_pkg::A_MIRROR) begin
          plan_nxt[0] = '{cbm_pkg::KIND_MIRROR, 3'd0, {5'd0, data_r}};
          cnt_nxt = 4'd1;
        end else if (addr_r == cbm_pkg::A_SRAM) begin
          plan_nxt[0] = '{cbm_pkg::KIND_SRAM, 3'd3, {10'd0, data_r[2:0]}};
          cnt_nxt = 4'd1;
        end else if (addr_r >= cbm_pkg::A_PRG_PG_LO && addr_r <= cbm_pkg::A_PRG_PG_HI) begin
          if (data_r[7]) begin
            if (pm == 2'd0) begin
              if (pg == 3'd7) begin
                for (int k = 0; k < 4; k++)
                  plan_nxt[k] = '{cbm_pkg::KIND_PRG, 3'(4 + k),
                                  {6'd0, data_r[6:2], 2'(k)}};
                cnt_nxt = 4'd4;
              end
            end else if (pm == 2'd1 || (pm == 2'd2 && pg == 3'd5)) begin
              if (pg == 3'd5 || pg == 3'd7) begin
                plan_nxt[0] = '{cbm_pkg::KIND_PRG, (pg == 3'd5) ? 3'd4 : 3'd6,
                                {6'd0, data_r[6:1], 1'b0}};
                plan_nxt[1] = '{cbm_pkg::KIND_PRG, (pg == 3'd5) ? 3'd5 : 3'd7,
                                {6'd0, data_r[6:1], 1'b1}};
                cnt_nxt = 4'd2;
              end
            end else if (pm == 2'd2) begin
              if (pg == 3'd6 || pg == 3'd7) begin
                plan_nxt[0] = '{cbm_pkg::KIND_PRG, pg, {6'd0, data_r[6:0]}};
                cnt_nxt = 4'd1;
              end
            end else begin
              plan_nxt[0] = '{cbm_pkg::KIND_PRG, pg, {6'd0, data_r[6:0]}};
              cnt_nxt = 4'd1;
            end
          end else begin
            if ((pm == 2'd1 || pm == 2'd2) && pg == 3'd5) begin
              plan_nxt[0] = '{cbm_pkg::KIND_SRAM, 3'd4, {10'd0, data_r[2:1], 1'b0}};
              plan_nxt[1] = '{cbm_pkg::KIND_SRAM, 3'd5, {10'd0, data_r[2:1], 1'b1}};
              cnt_nxt = 4'd2;
            end else if ((pm == 2'd2 && pg == 3'd6) ||
                         (pm == 2'd3 && pg >= 3'd4 && pg <= 3'd6)) begin
              plan_nxt[0] = '{cbm_pkg::KIND_SRAM, pg, {10'd0, data_r[2:0]}};
              cnt_nxt = 4'd1;
            end
            for (int i = 0; i < 4; i++)
              plan_nxt[32'(cnt_nxt) + i] = '{cbm_pkg::KIND_PROT, 3'(3 + i), {12'd0, prot}};
            cnt_nxt = cnt_nxt + 4'd4;
          end
        end else if (addr_r >= cbm_pkg::A_CHR0_LO && addr_r <= cbm_pkg::A_CHR0_HI) begin
          for (int s = 0; s < 8; s++)
            plan_nxt[s] = '{cbm_pkg::KIND_CHR, 3'(s),
                            chr_bank(chr_mode_r, upper_r,
                                     regs_v[chr_idx(chr_mode_r, 3'(s))], 3'(s))};
          cnt_nxt = 4'd8;
        end
      end
      cbm_pkg::MODE_RD: begin
        if (addr_r == cbm_pkg::A_IRQ_ST) rd_nxt = {pend_r, vbl_r, 6'd0};
        else if (addr_r == cbm_pkg::A_MUL_A) rd_nxt = prod[7:0];
        else if (addr_r == cbm_pkg::A_MUL_B) rd_nxt = prod[15:8];
        else if (in_ext) rd_nxt = ram_q;
      end
      cbm_pkg::MODE_TICK: ;
      cbm_pkg::MODE_LATCH: begin
        if (ext_mode_r == 2'd1 && fset_r) begin
          for (int s = 0; s < 8; s++)
            plan_nxt[s] = '{cbm_pkg::KIND_CHR, 3'(s),
                            {3'd0, upper_r, ram_q[5:0], 2'(s)}};
          rd_nxt = {4'd0, ram_q[7:6], 2'b01};
        end else begin
          for (int s = 0; s < 8; s++)
            plan_nxt[s] = '{cbm_pkg::KIND_CHR, 3'(s),
                            chr_bank(chr_mode_r, upper_r,
                                     chr_regs_r[{fset_r, 3'b000} + chr_idx(chr_mode_r, 3'(s))],
                                     3'(s))};
        end
        cnt_nxt = 4'd8;
      end
      default: ;
    endcase
  end

  // Control and state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cbm_pkg::ST_CLEAR;
      clr_r <= '0;
      idx_r <= 4'd0;
      prg_mode_r <= 2'd3; chr_mode_r <= 2'd3;
      key_a_r <= 2'd2; key_b_r <= 2'd1; ext_mode_r <= 2'd0; upper_r <= 2'd0;
      for (int i = 0; i < 8; i++) begin
        chr_regs_r[i]     <= 8'(i);
        chr_regs_r[8 + i] <= 8'((i % 4) + 4);
      end
      cmp_r <= 8'd0; mcand_r <= 8'd0; mplier_r <= 8'd0;
      irq_en_r <= 1'b0; pend_r <= 1'b0; vbl_r <= 1'b0; irq_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == cbm_pkg::ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (state_r == cbm_pkg::ST_READ) begin
        idx_r <= 4'd0;
        for (int i = 0; i < 8; i++) plan_r[i] <= plan_nxt[i];
        cnt_r <= cnt_nxt;
        rd_r  <= rd_nxt;
        unique case (mode_r)
          cbm_pkg::MODE_WR: begin
            if (addr_r == cbm_pkg::A_PRG_MODE) prg_mode_r <= data_r[1:0];
            if (addr_r == cbm_pkg::A_CHR_MODE) chr_mode_r <= data_r[1:0];
            if (addr_r == cbm_pkg::A_KEY_A) key_a_r <= data_r[1:0];
            if (addr_r == cbm_pkg::A_KEY_B) key_b_r <= data_r[1:0];
            if (addr_r == cbm_pkg::A_EXT_MODE) ext_mode_r <= data_r[1:0];
            if (addr_r >= cbm_pkg::A_CHR0_LO && addr_r <= cbm_pkg::A_CHR0_HI)
              chr_regs_r[{1'b0, pg}] <= data_r;
            if (addr_r >= cbm_pkg::A_CHR1_LO && addr_r <= cbm_pkg::A_CHR1_HI) begin
              chr_regs_r[{2'b10, pg[1:0]}] <= data_r;
              chr_regs_r[{2'b11, pg[1:0]}] <= data_r;
            end
            if (addr_r == cbm_pkg::A_CHR_UP) upper_r <= data_r[1:0];
            if (addr_r == cbm_pkg::A_IRQ_CMP) begin cmp_r <= data_r; irq_r <= 1'b0; end
            if (addr_r == cbm_pkg::A_IRQ_ST) begin irq_en_r <= data_r[7]; irq_r <= 1'b0; end
            if (addr_r == cbm_pkg::A_MUL_A) mcand_r <= data_r;
            if (addr_r == cbm_pkg::A_MUL_B) mplier_r <= data_r;
          end
          cbm_pkg::MODE_RD: begin
            if (addr_r == cbm_pkg::A_IRQ_ST) begin pend_r <= 1'b0; irq_r <= 1'b0; end
          end
          cbm_pkg::MODE_TICK: begin
            if (line_r <= 9'd240) begin
              if (line_r == {1'b0, cmp_r} && rend_r) begin
                pend_r <= 1'b1;
                if (irq_en_r) irq_r <= 1'b1;
              end else if (pend_r && irq_en_r) irq_r <= 1'b1;
            end else vbl_r <= 1'b1;
          end
          default: ;
        endcase
      end
      if (state_r == cbm_pkg::ST_EMIT && out_take) idx_r <= idx_r + 4'd1;
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (acc_in) begin
      mode_r <= in_mode; addr_r <= in_addr; data_r <= in_data;
      line_r <= in_scanline; rend_r <= in_rendering_enabled; fset_r <= in_fetch_set;
    end
  end

endmodule

// ===== sv/cbm_checker.sv =====
module cbm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_kind,
  input logic       out_last,
  input logic       out_irq
);
  // Final request carries the final kind
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_kind == cbm_pkg::KIND_FINAL)
    else $error("final request with remap kind");

  // Remap requests never carry the final kind
  a_remap_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_kind != cbm_pkg::KIND_FINAL)
    else $error("remap request with final kind");

  // No new input while results are pending
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while results pending");

  // Irq level steady within one event's sequence
  a_irq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(out_valid) && !$past(out_last) |-> $stable(out_irq))
    else $error("irq changed within an event");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind))
    else $error("stalled result changed");
endmodule

bind cartridge_bank_mapper_irq cbm_checker u_cbm_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
  .out_last(out_last), .out_irq(out_irq)
);

// ===== dv/cartridge_bank_mapper_irq_tb.sv =====
`timescale 1ns / 1ps

module cartridge_bank_mapper_irq_tb;

  localparam logic [15:0] A_UNMAPPED  = 16'hffff;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_mode;
  logic [15:0] in_addr;
  logic [7:0]  in_data;
  logic [8:0]  in_scanline;
  logic        in_rendering_enabled;
  logic        in_fetch_set;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_kind;
  logic [2:0]  out_slot;
  logic [12:0] out_bank;
  logic [7:0]  out_read_data;
  logic        out_irq;
  logic        out_last;

  cartridge_bank_mapper_irq u_dut (.*);

  typedef struct {
    logic [1:0]  mode;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [8:0]  line;
    logic        rend;
    logic        fset;
    bit          typed;   // final read data given by hand
    logic [7:0]  rd;
  } bus_req_t;

  typedef struct {
    logic [2:0]  kind;
    logic [2:0]  slot;
    logic [12:0] bank;
    logic [7:0]  rd;
    logic        irq;
    logic        last;
  } remap_t;

  remap_t   remap_q[$];
  remap_t   event_items[$];
  bus_req_t directed[$];
  int       errors;
  int       tx_idle_pct;
  int       rx_idle_pct;

  // Mapper shadow state
  logic [1:0] m_prg_mode, m_chr_mode, m_key_a, m_key_b, m_ext_mode, m_chr_up;
  logic [7:0] m_chr_regs [16];
  logic [7:0] m_cmp_line, m_mul_a, m_mul_b;
  logic       m_irq_en, m_pending, m_vblank, m_irq;
  logic [7:0] m_ext_ram [1024];

  function automatic void mapper_reset();
    m_prg_mode = 2'd3; m_chr_mode = 2'd3;
    m_key_a = 2'd2; m_key_b = 2'd1; m_ext_mode = '0; m_chr_up = '0;
    for (int i = 0; i < 8; i++) begin
      m_chr_regs[i]     = 8'(i);
      m_chr_regs[8 + i] = 8'((i & 3) + 4);
    end
    m_cmp_line = '0; m_mul_a = '0; m_mul_b = '0;
    m_irq_en = 0; m_pending = 0; m_vblank = 0; m_irq = 0;
    for (int i = 0; i < 1024; i++) m_ext_ram[i] = '0;
  endfunction

  function automatic void add_item(logic [2:0] kind, int slot, int bank);
    remap_t r;
    r.kind = kind; r.slot = 3'(slot); r.bank = 13'(bank);
    r.rd = '0; r.irq = 0; r.last = 0;
    event_items.push_back(r);
  endfunction

  function automatic void add_protect();
    logic flag;
    flag = !(m_key_a == 2'd2 && m_key_b == 2'd1);
    for (int s = 3; s <= 6; s++) add_item(cbm_pkg::KIND_PROT, s, flag);
  endfunction

  function automatic void add_chr(logic set);
    int idx, scale, off, r;
    for (int s = 0; s < 8; s++) begin
      case (m_chr_mode)
        2'd0: begin idx = 7; scale = 8; off = s; end
        2'd1: begin idx = (s < 4) ? 3 : 7; scale = 4; off = s & 3; end
        2'd2: begin idx = (s & 6) + 1; scale = 2; off = s & 1; end
        default: begin idx = s; scale = 1; off = 0; end
      endcase
      r = (int'(m_chr_up) << 8) | m_chr_regs[set * 8 + idx];
      add_item(cbm_pkg::KIND_CHR, s, r * scale + off);
    end
  endfunction

  // PRG page write: ROM when bit 7 set, else RAM plus protect items
  function automatic void map_cpu_page(int page, logic [7:0] v);
    int m;
    m = m_prg_mode;
    if (v[7]) begin
      if (m == 0) begin
        if (page == 7)
          for (int k = 0; k < 4; k++)
            add_item(cbm_pkg::KIND_PRG, 4 + k, (v & 8'h7c) + k);
      end else if (m == 1 || (m == 2 && page == 5)) begin
        if (page == 5 || page == 7) begin
          add_item(cbm_pkg::KIND_PRG, (page == 5) ? 4 : 6, v & 8'h7e);
          add_item(cbm_pkg::KIND_PRG, (page == 5) ? 5 : 7, (v & 8'h7e) + 1);
        end
      end else if (m == 2) begin
        if (page == 6 || page == 7) add_item(cbm_pkg::KIND_PRG, page, v & 8'h7f);
      end else begin
        add_item(cbm_pkg::KIND_PRG, page, v & 8'h7f);
      end
    end else begin
      if ((m == 1 || m == 2) && page == 5) begin
        add_item(cbm_pkg::KIND_SRAM, 4, v & 8'h06);
        add_item(cbm_pkg::KIND_SRAM, 5, (v & 8'h06) + 1);
      end else if (m == 2 && page == 6) begin
        add_item(cbm_pkg::KIND_SRAM, 6, v & 7);
      end else if (m == 3 && page >= 4 && page <= 6) begin
        add_item(cbm_pkg::KIND_SRAM, page, v & 7);
      end
      add_protect();
    end
  endfunction

  // Works out the remap sequence of one accepted request
  function automatic void predict_remaps(bus_req_t q);
    logic [7:0]  rd, e;
    logic [15:0] prod;
    remap_t      fin;
    int          b;
    event_items.delete();
    rd = '0;
    case (q.mode)
      cbm_pkg::MODE_WR: begin
        if (q.addr == cbm_pkg::A_PRG_MODE) m_prg_mode = q.data[1:0];
        else if (q.addr == cbm_pkg::A_CHR_MODE) m_chr_mode = q.data[1:0];
        else if (q.addr == cbm_pkg::A_KEY_A) begin
          m_key_a = q.data[1:0]; add_protect();
        end else if (q.addr == cbm_pkg::A_KEY_B) begin
          m_key_b = q.data[1:0]; add_protect();
        end else if (q.addr == cbm_pkg::A_EXT_MODE) m_ext_mode = q.data[1:0];
        else if (q.addr == cbm_pkg::A_MIRROR) add_item(cbm_pkg::KIND_MIRROR, 0, q.data);
        else if (q.addr == cbm_pkg::A_SRAM) add_item(cbm_pkg::KIND_SRAM, 3, q.data & 7);
        else if (q.addr >= cbm_pkg::A_PRG_PG_LO && q.addr <= cbm_pkg::A_PRG_PG_HI)
          map_cpu_page(q.addr & 7, q.data);
        else if (q.addr >= cbm_pkg::A_CHR0_LO && q.addr <= cbm_pkg::A_CHR0_HI) begin
          m_chr_regs[q.addr & 7] = q.data;
          add_chr(0);
        end else if (q.addr >= cbm_pkg::A_CHR1_LO && q.addr <= cbm_pkg::A_CHR1_HI) begin
          m_chr_regs[8 + (q.addr & 3)]  = q.data;
          m_chr_regs[12 + (q.addr & 3)] = q.data;
        end else if (q.addr == cbm_pkg::A_CHR_UP) m_chr_up = q.data[1:0];
        else if (q.addr == cbm_pkg::A_IRQ_CMP) begin m_cmp_line = q.data; m_irq = 0; end
        else if (q.addr == cbm_pkg::A_IRQ_ST) begin m_irq_en = q.data[7]; m_irq = 0; end
        else if (q.addr == cbm_pkg::A_MUL_A) m_mul_a = q.data;
        else if (q.addr == cbm_pkg::A_MUL_B) m_mul_b = q.data;
        else if (q.addr >= cbm_pkg::A_EXT_LO) begin
          if (q.addr <= cbm_pkg::A_EXT_HI) m_ext_ram[q.addr[9:0]] = q.data;
        end
      end
      cbm_pkg::MODE_RD: begin
        prod = m_mul_a * m_mul_b;
        if (q.addr == cbm_pkg::A_IRQ_ST) begin
          rd = {m_pending, m_vblank, 6'd0};
          m_pending = 0; m_irq = 0;
        end else if (q.addr == cbm_pkg::A_MUL_A) rd = prod[7:0];
        else if (q.addr == cbm_pkg::A_MUL_B) rd = prod[15:8];
        else if (q.addr >= cbm_pkg::A_EXT_LO && q.addr <= cbm_pkg::A_EXT_HI)
          rd = m_ext_ram[q.addr[9:0]];
      end
      cbm_pkg::MODE_TICK: begin
        if (q.line <= 9'd240) begin
          if (q.line == {1'b0, m_cmp_line} && q.rend) m_pending = 1;
          if (m_pending && m_irq_en) m_irq = 1;
        end else begin
          m_vblank = 1;
        end
      end
      default: begin
        if (m_ext_mode == 2'd1 && q.fset) begin
          e = m_ext_ram[q.addr[9:0]];
          b = ((int'(m_chr_up) << 6) | (e & 8'h3f)) << 2;
          for (int k = 0; k < 8; k++) add_item(cbm_pkg::KIND_CHR, k, b + (k & 3));
          rd = ((e & 8'hc0) >> 4) | 8'h01;
        end else begin
          add_chr(q.fset);
        end
      end
    endcase
    fin.kind = cbm_pkg::KIND_FINAL; fin.slot = '0; fin.bank = '0;
    fin.rd = q.typed ? q.rd : rd; fin.irq = 0; fin.last = 1;
    event_items.push_back(fin);
    foreach (event_items[i]) begin
      event_items[i].irq = m_irq;
      remap_q.push_back(event_items[i]);
    end
  endfunction

  // Clock
  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Result stall
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  // Result check
  always @(posedge clk) begin
    remap_t x;
    if (rst_n && out_valid && !out_stall) begin
      if (remap_q.size() == 0) begin
        $error("unexpected result kind=%0d slot=%0d", out_kind, out_slot);
        errors++;
      end else begin
        x = remap_q.pop_front();
        if (out_kind !== x.kind) begin
          $error("kind exp %0d got %0d", x.kind, out_kind); errors++;
        end
        if (out_slot !== x.slot) begin
          $error("slot exp %0d got %0d", x.slot, out_slot); errors++;
        end
        if (out_bank !== x.bank) begin
          $error("bank exp %0d got %0d", x.bank, out_bank); errors++;
        end
        if (out_read_data !== x.rd) begin
          $error("read_data exp %0h got %0h", x.rd, out_read_data); errors++;
        end
        if (out_irq !== x.irq) begin
          $error("irq exp %0d got %0d", x.irq, out_irq); errors++;
        end
        if (out_last !== x.last) begin
          $error("last exp %0d got %0d", x.last, out_last); errors++;
        end
      end
    end
  end

  task automatic send_request(bus_req_t q);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_mode <= q.mode; in_addr <= q.addr; in_data <= q.data;
    in_scanline <= q.line; in_rendering_enabled <= q.rend; in_fetch_set <= q.fset;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_remaps(q);
  endtask

  function automatic bus_req_t req(logic [1:0] mode, logic [15:0] addr, logic [7:0] data,
                                   logic [8:0] line = 0, logic rend = 0, logic fset = 0,
                                   bit typed = 0, logic [7:0] rd = 0);
    bus_req_t q;
    q.mode = mode; q.addr = addr; q.data = data; q.line = line;
    q.rend = rend; q.fset = fset; q.typed = typed; q.rd = rd;
    return q;
  endfunction

  // Mostly decoded registers with random content, some noise
  function automatic bus_req_t random_req();
    bus_req_t    q;
    logic [15:0] regs [13] = '{cbm_pkg::A_PRG_MODE, cbm_pkg::A_CHR_MODE, cbm_pkg::A_KEY_A,
                               cbm_pkg::A_KEY_B, cbm_pkg::A_EXT_MODE, cbm_pkg::A_MIRROR,
                               cbm_pkg::A_SRAM, cbm_pkg::A_CHR_UP, cbm_pkg::A_IRQ_CMP,
                               cbm_pkg::A_IRQ_ST, cbm_pkg::A_MUL_A, cbm_pkg::A_MUL_B,
                               cbm_pkg::A_PRG_PG_LO};
    int          pick;
    q = req(2'($urandom_range(3)), '0, 8'($urandom));
    pick = $urandom_range(99);
    if (pick < 40)
      q.addr = regs[$urandom_range(12)] + 16'((pick < 12) ? $urandom_range(3) : 0);
    else if (pick < 55) q.addr = cbm_pkg::A_CHR0_LO + 16'($urandom_range(11));
    else if (pick < 80) q.addr = cbm_pkg::A_EXT_LO + 16'($urandom_range(1023));
    else if (pick < 85) q.addr = cbm_pkg::A_EXT_LO + 16'($urandom_range(15)) - 16'd8;
    else q.addr = 16'($urandom);
    if (q.mode == cbm_pkg::MODE_TICK && $urandom_range(1)) q.line = {1'b0, m_cmp_line};
    else q.line = 9'($urandom_range(261));
    q.rend = 1'($urandom_range(1));
    q.fset = 1'($urandom_range(1));
    if (q.mode == cbm_pkg::MODE_WR && q.addr == cbm_pkg::A_IRQ_CMP)
      q.data = 8'($urandom_range(240));
    return q;
  endfunction

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int wait_cycles;
    errors = 0; tx_idle_pct = 22; rx_idle_pct = 81;
    rst_n = 0; in_valid = 0; out_stall = 0;
    in_mode = '0; in_addr = '0; in_data = '0; in_scanline = '0;
    in_rendering_enabled = 0; in_fetch_set = 0;
    mapper_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1;

    // Directed: power-up reads, multiplier extremes, irq, ext RAM latch
    directed.push_back(req(cbm_pkg::MODE_RD, cbm_pkg::A_IRQ_ST, 0, 0, 0, 0, 1, 8'h00));
    directed.push_back(req(cbm_pkg::MODE_RD, cbm_pkg::A_MUL_A, 0, 0, 0, 0, 1, 8'h00));
    directed.push_back(req(cbm_pkg::MODE_LATCH, 0, 0));
    directed.push_back(req(cbm_pkg::MODE_WR, cbm_pkg::A_MUL_A, 8'hff));
    directed.push_back(req(cbm_pkg::MODE_WR, cbm_pkg::A_MUL_B, 8'hff));
    directed.push_back(req(cbm_pkg::MODE_RD, cbm_pkg::A_MUL_A, 0, 0, 0, 0, 1, 8'h01));
    directed.push_back(req(cbm_pkg::MODE_RD, cbm_pkg::A_MUL_B, 0, 0, 0, 0, 1, 8'hfe));
    directed.push_back(req(cbm_pkg::MODE_RD, A_UNMAPPED, 0, 0, 0, 0, 1, 8'h00));
    directed.push_back(req(cbm_pkg::MODE_WR, A_UNMAPPED, 8'hff));
    directed.push_back(req(cbm_pkg::MODE_WR, cbm_pkg::A_KEY_A, 8'h00));
    directed.push_back(req(cbm_pkg::MODE_WR, cbm_pkg::A_MIRROR, 8'hff));
    directed.push_back(req(cbm_pkg::MODE_WR, cbm_pkg::A_SRAM, 8'hff));
    directed.push_back(req(cbm_pkg::MODE_WR, cbm_pkg::A_PRG_MODE, 8'h00));
    directed.push_back(req(cbm_pkg::MODE_WR, cbm_pkg::A_PRG_PG_HI, 8'hff));
    directed.push_back(req(cbm_pkg::MODE_WR, cbm_pkg::A_PRG_PG_LO, 8'h00));
    directed.push_back(req(cbm_pkg::MODE_WR, cbm_pkg::A_CHR_UP, 8'hff));
    directed.push_back(req(cbm_pkg::MODE_WR, cbm_pkg::A_CHR0_HI, 8'hff));
    directed.push_back(req(cbm_pkg::MODE_WR, cbm_pkg::A_CHR1_HI, 8'hff));
    directed.push_back(req(cbm_pkg::MODE_LATCH, A_UNMAPPED, 0, 0, 0, 1));
    directed.push_back(req(cbm_pkg::MODE_WR, cbm_pkg::A_EXT_MODE, 8'h01));
    directed.push_back(req(cbm_pkg::MODE_WR, cbm_pkg::A_EXT_HI, 8'hff));
    directed.push_back(req(cbm_pkg::MODE_LATCH, 16'h03ff, 0, 0, 0, 1, 1, 8'h0d));
    directed.push_back(req(cbm_pkg::MODE_WR, cbm_pkg::A_IRQ_CMP, 8'd240));
    directed.push_back(req(cbm_pkg::MODE_WR, cbm_pkg::A_IRQ_ST, 8'h80));
    directed.push_back(req(cbm_pkg::MODE_TICK, 0, 0, 9'd240, 1));
    directed.push_back(req(cbm_pkg::MODE_TICK, 0, 0, 9'd261, 0));
    directed.push_back(req(cbm_pkg::MODE_RD, cbm_pkg::A_IRQ_ST, 0, 0, 0, 0, 1, 8'hc0));
    foreach (directed[i]) send_request(directed[i]);

    // Random phases with swapped idle pressure, then none
    repeat (170) send_request(random_req());
    tx_idle_pct = 81; rx_idle_pct = 22;
    repeat (170) send_request(random_req());
    tx_idle_pct = 0; rx_idle_pct = 0;
    repeat (170) send_request(random_req());
    in_valid <= 0;

    // Drain
    wait_cycles = 0;
    while (remap_q.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (20) @(posedge clk);
    if (errors == 0 && remap_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/cbm_pkg.sv
sv/cartridge_bank_mapper_irq.sv
sv/cbm_checker.sv
dv/cartridge_bank_mapper_irq_tb.sv
